// ----- src/ztf_pkg.sv -----
// shared types, constants and a helper function for the z-buffered triangle fill unit
package ztf_pkg;

    localparam int SCREEN_COLS = 40;
    localparam int SCREEN_ROWS = 26;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int WALK_LIMIT  = 4096;
    localparam int BUDGET_W    = $clog2(WALK_LIMIT) + 1;
    localparam logic [7:0] DEPTH_RESET = 8'hFF;
    localparam logic [7:0] GLYPH_RESET = 8'h00;
    localparam logic signed [7:0] ERR_HI = 8'sd64;
    localparam logic signed [7:0] ERR_LO = -8'sd63;
    localparam logic [7:0] COL_MAX = 8'(SCREEN_COLS - 1);
    localparam logic [7:0] ROW_MAX = 8'(SCREEN_ROWS - 1);

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic signed [7:0] ax;
        logic signed [7:0] ay;
        logic signed [7:0] bx;
        logic signed [7:0] by_row;
        logic signed [7:0] cx;
        logic signed [7:0] cy;
        logic [7:0]       depth_in;
        logic [7:0]       glyph_in;
        logic [10:0]      cell_addr;
    } t_in_word;

    typedef struct packed {
        logic [7:0] cell_depth;
        logic [7:0] cell_glyph;
        logic       aborted;
    } t_out_word;

    // datapath commands
    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_LOAD     = 4'd1;  // latch request and sort
    localparam logic [3:0] CMD_INIT1    = 4'd2;  // init both edges for phase one
    localparam logic [3:0] CMD_INIT2    = 4'd3;  // reinit edge a from middle vertex
    localparam logic [3:0] CMD_STEP_A   = 4'd4;
    localparam logic [3:0] CMD_STEP_B   = 4'd5;
    localparam logic [3:0] CMD_SPAN_SET = 4'd6;
    localparam logic [3:0] CMD_SPAN_RD  = 4'd7;
    localparam logic [3:0] CMD_SPAN_WR  = 4'd8;
    localparam logic [3:0] CMD_TICK     = 4'd9;
    localparam logic [3:0] CMD_CLR      = 4'd10;
    localparam logic [3:0] CMD_RD       = 4'd11;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic two_phase;   // start row differs from middle row
        logic err_bad;     // either initialized edge fails range check
        logic a_done;
        logic b_done;
        logic a_more;      // edge a needs another micro step
        logic b_more;
        logic budget_ok;   // budget above zero
        logic span_more;   // span column still within range
        logic span_empty;
        logic clr_last;
    } t_sts;

    function automatic logic signed [7:0] dbl_sat(input logic signed [7:0] e);
        logic signed [8:0] d;
        d = {e, 1'b0};
        if (d > 9'sd127) return 8'sd127;
        if (d < -9'sd128) return -8'sd128;
        return d[7:0];
    endfunction

endpackage

// ----- src/ztf_ram.sv -----
// generic single port ram with registered read
module ztf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- src/ztf_datapath.sv -----
// edge walkers, span generator and screen stores
module ztf_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ztf_pkg::t_cmd    i_cmd,
    input  ztf_pkg::t_in_word i_word,
    output ztf_pkg::t_sts    o_sts,
    output logic [7:0]       o_rd_depth,
    output logic [7:0]       o_rd_glyph,
    output logic             o_rd_valid
);
    import ztf_pkg::*;

    typedef struct packed {
        logic signed [7:0] x, y, tx, ty, dx, dy, err;
        logic sxn, syn;  // step negative
        logic done;
    } t_walk;

    t_walk r_a, r_b, n_a, n_b;
    logic signed [7:0] r_sx, r_sy, r_m1x, r_m1y, r_m2x, r_m2y;
    logic signed [7:0] r_a_nxt, r_b_nxt;  // target row of the current row step
    logic [7:0] r_z, r_g;
    logic [ADDR_W-1:0] r_addr_in;
    logic [BUDGET_W-1:0] r_budget;
    logic signed [7:0] r_col, r_hi;
    logic [ADDR_W-1:0] r_row_base, r_clr_addr;
    logic r_rd_oor;

    function automatic t_walk w_init(input logic signed [7:0] x0, y0, x1, y1);
        t_walk w;
        logic signed [8:0] ddx, ddy;
        ddx = 9'(x1) - 9'(x0);
        ddy = 9'(y1) - 9'(y0);
        w.x = x0; w.y = y0; w.tx = x1; w.ty = y1;
        w.dx = ddx[8] ? 8'(-ddx) : ddx[7:0];
        w.dy = ddy[8] ? ddy[7:0] : 8'(-ddy);
        w.err = w.dx + w.dy;
        w.sxn = !(x0 < x1);
        w.syn = !(y0 < y1);
        w.done = (x0 == x1) && (y0 == y1);
        return w;
    endfunction

    function automatic logic w_more(input t_walk w, input logic signed [7:0] nxt);
        return !w.done && ((dbl_sat(w.err) > w.dx) || (w.y != nxt));
    endfunction

    function automatic t_walk w_step(input t_walk w);
        t_walk o;
        logic signed [7:0] e2;
        o = w;
        e2 = dbl_sat(w.err);
        if (e2 >= w.dy) begin
            o.err = o.err + w.dy;
            o.x = w.sxn ? w.x - 8'sd1 : w.x + 8'sd1;
        end
        if (e2 <= w.dx) begin
            o.err = o.err + w.dx;
            o.y = w.syn ? w.y - 8'sd1 : w.y + 8'sd1;
        end
        o.done = (o.x == w.tx) && (o.y == w.ty);
        return o;
    endfunction

    // largest-row-first sort of vertices
    logic signed [7:0] s_sx, s_sy, s_m1x, s_m1y, s_m2x, s_m2y;
    always_comb begin
        logic signed [7:0] x1, y1, x2, y2, x3, y3;
        x1 = i_word.ax; y1 = i_word.ay; x2 = i_word.bx;
        y2 = i_word.by_row; x3 = i_word.cx; y3 = i_word.cy;
        if (y1 <= y2) begin
            if (y2 <= y3) begin
                s_sx = x3; s_sy = y3; s_m1x = x2; s_m1y = y2; s_m2x = x1; s_m2y = y1;
            end else begin
                s_sx = x2; s_sy = y2;
                if (y1 <= y3) begin
                    s_m1x = x3; s_m1y = y3; s_m2x = x1; s_m2y = y1;
                end else begin
                    s_m1x = x1; s_m1y = y1; s_m2x = x3; s_m2y = y3;
                end
            end
        end else begin
            if (y1 <= y3) begin
                s_sx = x3; s_sy = y3; s_m1x = x1; s_m1y = y1; s_m2x = x2; s_m2y = y2;
            end else begin
                s_sx = x1; s_sy = y1;
                if (y2 <= y3) begin
                    s_m1x = x3; s_m1y = y3; s_m2x = x2; s_m2y = y2;
                end else begin
                    s_m1x = x2; s_m1y = y2; s_m2x = x3; s_m2y = y3;
                end
            end
        end
    end

    logic two_phase;
    assign two_phase = (r_sy != r_m1y);

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        case (i_cmd.op)
            CMD_INIT1: begin
                if (two_phase) begin
                    n_a = w_init(r_sx, r_sy, r_m1x, r_m1y);
                    n_b = w_init(r_sx, r_sy, r_m2x, r_m2y);
                end else begin
                    n_a = w_init(r_sx, r_sy, r_m2x, r_m2y);
                    n_b = w_init(r_m1x, r_m1y, r_m2x, r_m2y);
                end
            end
            CMD_INIT2:  n_a = w_init(r_m1x, r_m1y, r_m2x, r_m2y);
            CMD_STEP_A: n_a = w_step(r_a);
            CMD_STEP_B: n_b = w_step(r_b);
            default: ;
        endcase
    end

    // span bounds
    logic signed [7:0] sp_lo, sp_hi;
    logic row_ok;
    always_comb begin
        sp_lo = (r_a.x < r_b.x) ? r_a.x : r_b.x;
        sp_hi = (r_a.x < r_b.x) ? r_b.x : r_a.x;
        if (sp_lo < 8'sd1) sp_lo = 8'sd1;
        if (sp_hi > $signed(COL_MAX)) sp_hi = $signed(COL_MAX);
        row_ok = (r_a.y > 8'sd0) && (r_a.y <= $signed(ROW_MAX));
    end

    logic [ADDR_W-1:0] span_addr;
    assign span_addr = r_row_base + ADDR_W'(r_col[6:0]);

    // store access
    logic [ADDR_W-1:0] ram_addr;
    logic ram_we;
    logic [7:0] d_wdata, g_wdata, d_rdata, g_rdata;
    logic span_hit;
    assign span_hit = (r_z < d_rdata);

    always_comb begin
        ram_addr = span_addr;
        ram_we = 1'b0;
        d_wdata = r_z;
        g_wdata = r_g;
        case (i_cmd.op)
            CMD_CLR: begin
                ram_addr = r_clr_addr;
                ram_we = 1'b1;
                d_wdata = DEPTH_RESET;
                g_wdata = GLYPH_RESET;
            end
            CMD_RD:      ram_addr = r_addr_in;
            CMD_SPAN_WR: ram_we = span_hit;
            default: ;
        endcase
    end

    ztf_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_depth (
        .i_clk, .i_we(ram_we), .i_addr(ram_addr), .i_wdata(d_wdata), .o_rdata(d_rdata)
    );
    ztf_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_glyph (
        .i_clk, .i_we(ram_we), .i_addr(ram_addr), .i_wdata(g_wdata), .o_rdata(g_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        if (i_cmd.op == CMD_LOAD) begin
            r_sx <= s_sx; r_sy <= s_sy; r_m1x <= s_m1x; r_m1y <= s_m1y;
            r_m2x <= s_m2x; r_m2y <= s_m2y;
            r_z <= i_word.depth_in;
            r_g <= i_word.glyph_in;
            r_addr_in <= i_word.cell_addr;
            r_rd_oor <= (i_word.cell_addr >= 11'(CELL_COUNT));
        end
        if (i_cmd.op == CMD_TICK) begin
            r_a_nxt <= r_a.syn ? r_a.y - 8'sd1 : r_a.y + 8'sd1;
            r_b_nxt <= r_b.syn ? r_b.y - 8'sd1 : r_b.y + 8'sd1;
        end
        if (i_cmd.op == CMD_SPAN_SET) begin
            r_col <= sp_lo;
            r_hi <= sp_hi;
            r_row_base <= ADDR_W'(r_a.y[6:0]) * ADDR_W'(SCREEN_COLS);
        end
        if (i_cmd.op == CMD_SPAN_WR) begin
            r_col <= r_col + 8'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
            r_clr_addr <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            o_rd_valid <= (i_cmd.op == CMD_RD);
            if (i_cmd.op == CMD_LOAD) begin
                r_budget <= BUDGET_W'(WALK_LIMIT);
            end else if ((i_cmd.op == CMD_TICK || i_cmd.op == CMD_STEP_A
                          || i_cmd.op == CMD_STEP_B) && r_budget != '0) begin
                r_budget <= r_budget - 1'b1;
            end
            if (i_cmd.op == CMD_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_rd_depth = r_rd_oor ? 8'd0 : d_rdata;
    assign o_rd_glyph = r_rd_oor ? 8'd0 : g_rdata;

    assign o_sts.two_phase = two_phase;
    assign o_sts.err_bad = (r_a.err > ERR_HI) || (r_a.err < ERR_LO)
                           || (r_b.err > ERR_HI) || (r_b.err < ERR_LO);
    assign o_sts.a_done = r_a.done;
    assign o_sts.b_done = r_b.done;
    assign o_sts.a_more = w_more(r_a, r_a_nxt);
    assign o_sts.b_more = w_more(r_b, r_b_nxt);
    assign o_sts.budget_ok = (r_budget != '0);
    assign o_sts.span_more = (r_col <= r_hi);
    assign o_sts.span_empty = !row_ok || (sp_lo > sp_hi);
    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(CELL_COUNT - 1));

    a_budget_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_budget <= BUDGET_W'(WALK_LIMIT))
        else $error("walk budget above limit");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && i_cmd.op == CMD_SPAN_WR |-> r_col >= 8'sd1 && r_col <= $signed(COL_MAX))
        else $error("span write outside columns");
    a_clr_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == CMD_CLR |-> r_clr_addr < ADDR_W'(CELL_COUNT))
        else $error("clear address past screen");
endmodule

// ----- src/ztf_ctrl.sv -----
// sequencer for clearing, reads and triangle walks
module ztf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_stall,
    input  ztf_pkg::t_sts     i_sts,
    output ztf_pkg::t_cmd     o_cmd,
    output logic              o_done,
    output logic              o_aborted,
    output logic              o_is_read
);
    import ztf_pkg::*;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_INIT = 4'd3,
        S_CHK = 4'd4, S_SPSET = 4'd5, S_SPRD = 4'd6, S_SPWR = 4'd7, S_LOOP = 4'd8,
        S_WA = 4'd9, S_WB = 4'd10, S_AFTER = 4'd11, S_DONE = 4'd12, S_RDW = 4'd13;

    logic [3:0] r_state, n_state;
    logic r_phase2, n_phase2, r_abort, n_abort, r_read, n_read;

    always_comb begin
        n_state = r_state;
        n_phase2 = r_phase2;
        n_abort = r_abort;
        n_read = r_read;
        o_cmd.op = CMD_NONE;
        o_in_stall = 1'b1;
        o_done = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.op = CMD_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_abort = 1'b0;
                    n_phase2 = 1'b0;
                    n_read = (i_req_type == REQ_READ);
                    n_state = (i_req_type == REQ_READ) ? S_RD : S_INIT;
                end
            end
            S_RD: begin
                o_cmd.op = CMD_RD;
                n_state = S_RDW;
            end
            S_RDW: n_state = S_DONE;
            S_INIT: begin
                o_cmd.op = CMD_INIT1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.err_bad) begin
                    n_abort = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SPSET;
                end
            end
            S_SPSET: begin
                o_cmd.op = CMD_SPAN_SET;
                n_state = i_sts.span_empty ? S_AFTER : S_SPRD;
            end
            S_SPRD: begin
                if (i_sts.span_more) begin
                    o_cmd.op = CMD_SPAN_RD;
                    n_state = S_SPWR;
                end else begin
                    n_state = S_AFTER;
                end
            end
            S_SPWR: begin
                o_cmd.op = CMD_SPAN_WR;
                n_state = S_SPRD;
            end
            S_AFTER: begin
                if (!r_phase2 && i_sts.two_phase) begin
                    if (i_sts.a_done) begin
                        o_cmd.op = CMD_INIT2;
                        n_phase2 = 1'b1;
                    end
                    n_state = S_LOOP;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if ((!r_phase2 && i_sts.two_phase) ? i_sts.a_done
                    : (i_sts.a_done || i_sts.b_done)) begin
                    n_state = S_DONE;
                end else if (!i_sts.budget_ok) begin
                    n_abort = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = CMD_TICK;
                    n_state = S_WA;
                end
            end
            S_WA: begin
                if (i_sts.a_more) begin
                    if (i_sts.budget_ok) o_cmd.op = CMD_STEP_A;
                    else n_state = S_WB;
                end else begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (i_sts.b_more && i_sts.budget_ok) begin
                    o_cmd.op = CMD_STEP_B;
                end else if (!i_sts.budget_ok) begin
                    n_abort = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SPSET;
                end
            end
            S_DONE: o_done = 1'b1;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_phase2 <= 1'b0;
            r_abort <= 1'b0;
            r_read <= 1'b0;
        end else begin
            r_state <= (r_state == S_DONE) ? S_IDLE : n_state;
            r_phase2 <= n_phase2;
            r_abort <= n_abort;
            r_read <= n_read;
        end
    end

    assign o_aborted = r_abort;
    assign o_is_read = r_read;

    a_idle_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> r_state == S_IDLE)
        else $error("input taken outside idle");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("double completion");
    a_read_no_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_read |-> !r_abort)
        else $error("read flagged aborted");
endmodule

// ----- src/zbuffered_triangle_fill_unit.sv -----
// top level of the z-buffered triangle fill unit
// after reset a clearing pass writes the reset depth and glyph to every screen cell before the first word is taken
// a read passes through the states S_RD, S_RDW and S_DONE before its result is registered
// a draw reads each span cell through the single store port and writes it where the new depth is smaller;
// it is bounded by the 4096-step walk budget and aborts when that budget runs out
// one word in flight; result sits in an output register until taken
module zbuffered_triangle_fill_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ztf_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ztf_pkg::t_out_word o_data
);
    import ztf_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic done, aborted, is_read, rd_valid, ctrl_stall;
    logic [7:0] rd_depth, rd_glyph;
    logic r_valid;
    t_out_word r_data;

    ztf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(i_valid && !r_valid), .i_req_type(i_data.req_type),
        .o_in_stall(ctrl_stall), .i_sts(sts), .o_cmd(cmd), .o_done(done),
        .o_aborted(aborted), .o_is_read(is_read)
    );

    ztf_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_word(i_data), .o_sts(sts),
        .o_rd_depth(rd_depth), .o_rd_glyph(rd_glyph), .o_rd_valid(rd_valid)
    );

    logic [7:0] r_hold_d, r_hold_g;
    always_ff @(posedge i_clk) begin
        if (rd_valid) begin
            r_hold_d <= rd_depth;
            r_hold_g <= rd_glyph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_data.cell_depth <= is_read ? r_hold_d : 8'd0;
            r_data.cell_glyph <= is_read ? r_hold_g : 8'd0;
            r_data.aborted <= aborted;
        end
    end

    assign o_stall = ctrl_stall || r_valid;
    assign o_valid = r_valid;
    assign o_data = r_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !r_valid || !i_stall)
        else $error("result overwritten");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid)
        else $error("result dropped");
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted while busy");
endmodule

// ----- tb/zbuffered_triangle_fill_unit_test.sv -----
// testbench for the z-buffered triangle fill unit: table-driven and random draws and reads
`timescale 1ns / 1ps

module zbuffered_triangle_fill_unit_test;
    import ztf_pkg::*;

    typedef struct {
        int x, y, tx, ty, dx, dy, err, sx, sy;
        bit done;
    } t_edge;

    typedef struct {
        t_in_word  word;
        bit        fixed;
        t_out_word result;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_data;

    logic [7:0] depth_mem [CELL_COUNT];
    logic [7:0] glyph_mem [CELL_COUNT];
    int         steps_left;
    t_out_word  pending_results [$];
    t_row       table_rows [$];
    int         mismatches = 0;
    bit         quiet_tail = 1'b0;

    zbuffered_triangle_fill_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int wrap_byte(int v);
        logic signed [7:0] b;
        b = v[7:0];
        return int'(b);
    endfunction

    function automatic int abs_int(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int double_sat(int e);
        int d;
        d = 2 * e;
        if (d > 127) return 127;
        if (d < -128) return -128;
        return d;
    endfunction

    function automatic bit take_step();
        if (steps_left <= 0) return 1'b0;
        steps_left--;
        return 1'b1;
    endfunction

    function automatic void edge_setup(ref t_edge w, input int x0, y0, x1, y1);
        w.x = x0; w.y = y0; w.tx = x1; w.ty = y1;
        w.dx = wrap_byte(abs_int(x1 - x0));
        w.dy = wrap_byte(-abs_int(y1 - y0));
        w.err = wrap_byte(w.dx + w.dy);
        w.sx = (x0 < x1) ? 1 : -1;
        w.sy = (y0 < y1) ? 1 : -1;
        w.done = (x0 == x1) && (y0 == y1);
    endfunction

    function automatic bit err_in_range(t_edge w);
        return w.err <= 64 && w.err >= -63;
    endfunction

    function automatic void edge_advance(ref t_edge w);
        int nxt, e2;
        nxt = wrap_byte(w.y + w.sy);
        e2 = double_sat(w.err);
        while (!w.done && (e2 > w.dx || w.y != nxt)) begin
            if (!take_step()) return;
            if (e2 >= w.dy) begin
                w.err = wrap_byte(w.err + w.dy);
                w.x = wrap_byte(w.x + w.sx);
            end
            if (e2 <= w.dx) begin
                w.err = wrap_byte(w.err + w.dx);
                w.y = wrap_byte(w.y + w.sy);
            end
            w.done = (w.x == w.tx) && (w.y == w.ty);
            e2 = double_sat(w.err);
        end
    endfunction

    function automatic void paint_span(int xa, xb, r, logic [7:0] z, g);
        int lo, hi, a;
        lo = xa < xb ? xa : xb;
        hi = xa < xb ? xb : xa;
        if (r <= 0 || r >= SCREEN_ROWS) return;
        if (lo < 1) lo = 1;
        if (hi > SCREEN_COLS - 1) hi = SCREEN_COLS - 1;
        for (int c = lo; c <= hi; c++) begin
            a = r * SCREEN_COLS + c;
            if (z < depth_mem[a]) begin
                depth_mem[a] = z;
                glyph_mem[a] = g;
            end
        end
    endfunction

    function automatic bit fill_triangle(int x1, y1, x2, y2, x3, y3, logic [7:0] z, g);
        int px, py, m1x, m1y, m2x, m2y;
        t_edge ea, eb;
        if (y1 <= y2) begin
            if (y2 <= y3) begin
                px = x3; py = y3; m1x = x2; m1y = y2; m2x = x1; m2y = y1;
            end else begin
                px = x2; py = y2;
                if (y1 <= y3) begin
                    m1x = x3; m1y = y3; m2x = x1; m2y = y1;
                end else begin
                    m1x = x1; m1y = y1; m2x = x3; m2y = y3;
                end
            end
        end else begin
            if (y1 <= y3) begin
                px = x3; py = y3; m1x = x1; m1y = y1; m2x = x2; m2y = y2;
            end else begin
                px = x1; py = y1;
                if (y2 <= y3) begin
                    m1x = x3; m1y = y3; m2x = x2; m2y = y2;
                end else begin
                    m1x = x2; m1y = y2; m2x = x3; m2y = y3;
                end
            end
        end
        steps_left = WALK_LIMIT;
        if (py != m1y) begin
            edge_setup(ea, px, py, m1x, m1y);
            if (!err_in_range(ea)) return 1'b1;
            edge_setup(eb, px, py, m2x, m2y);
            if (!err_in_range(eb)) return 1'b1;
            paint_span(ea.x, eb.x, ea.y, z, g);
            while (!ea.done) begin
                if (!take_step()) return 1'b1;
                edge_advance(ea);
                edge_advance(eb);
                if (steps_left <= 0) return 1'b1;
                paint_span(ea.x, eb.x, ea.y, z, g);
            end
            edge_setup(ea, m1x, m1y, m2x, m2y);
            while (!ea.done && !eb.done) begin
                if (!take_step()) return 1'b1;
                edge_advance(ea);
                edge_advance(eb);
                if (steps_left <= 0) return 1'b1;
                paint_span(ea.x, eb.x, ea.y, z, g);
            end
        end else begin
            edge_setup(ea, px, py, m2x, m2y);
            if (!err_in_range(ea)) return 1'b1;
            edge_setup(eb, m1x, m1y, m2x, m2y);
            if (!err_in_range(eb)) return 1'b1;
            paint_span(ea.x, eb.x, ea.y, z, g);
            while (!ea.done && !eb.done) begin
                if (!take_step()) return 1'b1;
                edge_advance(ea);
                edge_advance(eb);
                if (steps_left <= 0) return 1'b1;
                paint_span(ea.x, eb.x, ea.y, z, g);
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out_word predict_cell(t_in_word w);
        t_out_word r;
        r = '0;
        if (w.req_type == REQ_READ) begin
            if (w.cell_addr < CELL_COUNT) begin
                r.cell_depth = depth_mem[w.cell_addr];
                r.cell_glyph = glyph_mem[w.cell_addr];
            end
        end else begin
            r.aborted = fill_triangle(w.ax, w.ay, w.bx, w.by_row, w.cx, w.cy,
                                      w.depth_in, w.glyph_in);
        end
        return r;
    endfunction

    function automatic t_in_word make_draw(int ax, ay, bx, by, cx, cy, int z, g);
        t_in_word w;
        w = '0;
        w.req_type = REQ_DRAW;
        w.ax = 8'(ax); w.ay = 8'(ay); w.bx = 8'(bx); w.by_row = 8'(by);
        w.cx = 8'(cx); w.cy = 8'(cy);
        w.depth_in = 8'(z); w.glyph_in = 8'(g);
        w.cell_addr = 11'($urandom);
        return w;
    endfunction

    function automatic t_in_word make_read(int addr);
        t_in_word w;
        w = t_in_word'(75'({$urandom, $urandom, $urandom}));
        w.req_type = REQ_READ;
        w.cell_addr = 11'(addr);
        return w;
    endfunction

    function automatic t_in_word random_word();
        int k, x0, y0, ext;
        k = $urandom_range(0, 99);
        if (k < 35) return make_read($urandom_range(0, 99) < 90 ?
                                     $urandom_range(0, CELL_COUNT - 1) : $urandom_range(0, 2047));
        if (k < 85) begin
            ext = $urandom_range(0, 9) == 0 ? 40 : 14;
            x0 = $urandom_range(0, SCREEN_COLS);
            y0 = $urandom_range(0, SCREEN_ROWS);
            return make_draw(x0, y0,
                             x0 + $urandom_range(0, 2 * ext) - ext,
                             y0 + $urandom_range(0, 2 * ext) - ext,
                             x0 + $urandom_range(0, 2 * ext) - ext,
                             y0 + $urandom_range(0, 2 * ext) - ext,
                             $urandom_range(0, 255), $urandom_range(0, 255));
        end
        return make_draw($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    task automatic add_row(t_in_word w, bit fixed, t_out_word r);
        t_row row;
        row.word = w;
        row.fixed = fixed;
        row.result = r;
        table_rows.push_back(row);
    endtask

    task automatic send_word(t_in_word w, bit fixed, t_out_word r);
        t_out_word exp_r;
        exp_r = predict_cell(w);
        pending_results.push_back(fixed ? r : exp_r);
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            i_data  <= t_in_word'(75'({$urandom, $urandom, $urandom}));
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    initial begin
        int stall_len;
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && !i_stall && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                stall_len = $urandom_range(1, 9);
                repeat (stall_len) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_data.cell_depth !== exp_r.cell_depth ||
                    o_data.cell_glyph !== exp_r.cell_glyph ||
                    o_data.aborted !== exp_r.aborted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: depth %h/%h glyph %h/%h aborted %b/%b (exp/act)",
                                 exp_r.cell_depth, o_data.cell_depth,
                                 exp_r.cell_glyph, o_data.cell_glyph,
                                 exp_r.aborted, o_data.aborted);
                end
            end
        end
    end

    initial begin
        #1s;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_out_word none, rst_cell, abort_r;
        none = '0;
        rst_cell = '0;
        rst_cell.cell_depth = DEPTH_RESET;
        abort_r = '0;
        abort_r.aborted = 1'b1;
        for (int i = 0; i < CELL_COUNT; i++) begin
            depth_mem[i] = DEPTH_RESET;
            glyph_mem[i] = GLYPH_RESET;
        end

        add_row(make_read(0), 1'b1, rst_cell);
        add_row(make_read(CELL_COUNT - 1), 1'b1, rst_cell);
        add_row(make_read(CELL_COUNT), 1'b1, none);
        add_row(make_read(2047), 1'b1, none);
        add_row(make_draw(0, 0, 127, 0, 0, -1, 0, 0), 1'b1, abort_r);
        add_row(make_draw(-128, -128, 127, 127, 0, 0, 9, 9), 1'b0, none);
        add_row(make_draw(5, 5, 5, 5, 5, 5, 100, 8'h41), 1'b0, none);
        add_row(make_read(5 * SCREEN_COLS + 5), 1'b0, none);
        add_row(make_draw(-5, -3, 50, 10, 20, 35, 200, 8'h2A), 1'b0, none);
        add_row(make_draw(10, 5, 30, 5, 20, 15, 255, 8'hFF), 1'b0, none);
        add_row(make_draw(10, 5, 30, 5, 20, 15, 199, 8'h80), 1'b0, none);
        add_row(make_draw(10, 5, 30, 5, 20, 15, 199, 8'h7F), 1'b0, none);
        add_row(make_read(8 * SCREEN_COLS + 20), 1'b0, none);
        add_row(make_draw(2, 20, 35, 20, 2, 2, 0, 8'h55), 1'b0, none);
        add_row(make_read(10 * SCREEN_COLS + 3), 1'b0, none);
        add_row(make_draw(1, 1, 39, 1, 20, 25, 50, 8'h01), 1'b0, none);
        add_row(make_draw(0, 0, 39, 25, 39, 0, 40, 8'hAA), 1'b0, none);
        add_row(make_read(1 * SCREEN_COLS + 39), 1'b0, none);
        add_row(make_draw(127, 127, -128, 127, 0, -128, 1, 2), 1'b0, none);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_rows[i]) send_word(table_rows[i].word, table_rows[i].fixed,
                                          table_rows[i].result);
        for (int n = 0; n < 550; n++) begin
            if (n == 480) quiet_tail = 1'b1;
            send_word(random_word(), 1'b0, none);
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
